// File: rtl/bcpn_pkg.sv
// Shared types and constants for the box closest-point / face-normal pipeline.
// Used by every module of the block; no dependencies.
package bcpn_pkg;

   localparam int NUM_AXES       = 3;
   localparam int NUM_FACES      = 6;
   localparam int FACE_BITS      = 3;
   localparam int CSR_INDEX_BITS = 3;

   // 1.0 in Q16.16, the reset value of the upper corner
   localparam int UPPER_RESET = 65536;

   // Face codes in tie-break order
   typedef enum logic [FACE_BITS-1:0] {
      FACE_POS_X = 3'd0,
      FACE_POS_Y = 3'd1,
      FACE_POS_Z = 3'd2,
      FACE_NEG_X = 3'd3,
      FACE_NEG_Y = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   // Register indexes on the write port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LOWER_X = 3'd0,
      CSR_LOWER_Y = 3'd1,
      CSR_LOWER_Z = 3'd2,
      CSR_UPPER_X = 3'd3,
      CSR_UPPER_Y = 3'd4,
      CSR_UPPER_Z = 3'd5
   } csr_index_type;

   // Per-item control carried along the pipeline
   typedef struct packed {
      logic                valid;
      logic                in_box;
      logic [NUM_AXES-1:0] below;
      logic [NUM_AXES-1:0] above;
   } ctl_type;

endpackage

// File: rtl/bcpn_csr.sv
// Box corner registers, written through the plain write port.
// Depends on bcpn_pkg.
module bcpn_csr #(
   parameter int COORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [bcpn_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic signed [COORD_BITS-1:0]          csr_write_data,
   output logic signed [COORD_BITS-1:0]          lower [bcpn_pkg::NUM_AXES],
   output logic signed [COORD_BITS-1:0]          upper [bcpn_pkg::NUM_AXES]
);
   import bcpn_pkg::*;

   logic signed [COORD_BITS-1:0] lower_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] upper_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] lower_in [NUM_AXES];
   logic signed [COORD_BITS-1:0] upper_in [NUM_AXES];

   // Index decode; unused indexes are dropped
   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LOWER_X: lower_in[0] = csr_write_data;
            CSR_LOWER_Y: lower_in[1] = csr_write_data;
            CSR_LOWER_Z: lower_in[2] = csr_write_data;
            CSR_UPPER_X: upper_in[0] = csr_write_data;
            CSR_UPPER_Y: upper_in[1] = csr_write_data;
            CSR_UPPER_Z: upper_in[2] = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            lower_ff[i] <= '0;
            upper_ff[i] <= COORD_BITS'(UPPER_RESET);
         end
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   assign lower = lower_ff;
   assign upper = upper_ff;

endmodule

// File: rtl/bcpn_prep.sv
// Front stages: face distances, inside test, six face keys and first level
// of the minimum tree. Depends on bcpn_pkg.
module bcpn_prep #(
   parameter int COORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [COORD_BITS-1:0]  point      [bcpn_pkg::NUM_AXES],
   input  logic signed [COORD_BITS-1:0]  lower      [bcpn_pkg::NUM_AXES],
   input  logic signed [COORD_BITS-1:0]  upper      [bcpn_pkg::NUM_AXES],
   output bcpn_pkg::ctl_type             stage_ctl,
   output logic signed [COORD_BITS-1:0]  stage_point [bcpn_pkg::NUM_AXES],
   output logic signed [COORD_BITS+1:0]  stage_key   [bcpn_pkg::NUM_AXES],
   output bcpn_pkg::face_type            stage_face  [bcpn_pkg::NUM_AXES]
);
   import bcpn_pkg::*;

   localparam int DW = COORD_BITS + 1;   // exact difference of two coords
   localparam int KW = COORD_BITS + 2;   // difference and its negation

   // Stage 1: distances to both bounds on each axis
   logic                         s1_valid_ff;
   logic signed [COORD_BITS-1:0] s1_point_ff [NUM_AXES];
   logic signed [DW-1:0]         s1_dh_ff    [NUM_AXES];
   logic signed [DW-1:0]         s1_dl_ff    [NUM_AXES];
   logic signed [DW-1:0]         s1_dh_in    [NUM_AXES];
   logic signed [DW-1:0]         s1_dl_in    [NUM_AXES];

   // Stage 2: control and first-level winners
   ctl_type                      s2_ctl_ff;
   ctl_type                      s2_ctl_in;
   logic signed [COORD_BITS-1:0] s2_point_ff [NUM_AXES];
   logic signed [KW-1:0]         s2_key_ff   [NUM_AXES];
   logic signed [KW-1:0]         s2_key_in   [NUM_AXES];
   face_type                     s2_face_ff  [NUM_AXES];
   face_type                     s2_face_in  [NUM_AXES];

   logic signed [KW-1:0]         key [NUM_FACES];

   // upper - point and point - lower
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         s1_dh_in[i] = DW'(upper[i]) - DW'(point[i]);
         s1_dl_in[i] = DW'(point[i]) - DW'(lower[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_point_ff <= point;
      s1_dh_ff    <= s1_dh_in;
      s1_dl_ff    <= s1_dl_in;
   end

   // Keys: face distance when inside, negated dot product when outside,
   // so both cases become a first-lowest minimum search
   always_comb begin
      s2_ctl_in.valid = s1_valid_ff;
      for (int i = 0; i < NUM_AXES; i++) begin
         s2_ctl_in.below[i] = s1_dl_ff[i][DW-1];
         s2_ctl_in.above[i] = s1_dh_ff[i][DW-1];
      end
      s2_ctl_in.in_box = ~|s2_ctl_in.below && ~|s2_ctl_in.above;

      for (int i = 0; i < NUM_AXES; i++) begin
         if (s2_ctl_in.in_box) begin
            key[i]     = KW'(s1_dh_ff[i]);
            key[i + 3] = KW'(s1_dl_ff[i]);
         end else if (s2_ctl_in.below[i]) begin
            key[i]     = -KW'(s1_dl_ff[i]);
            key[i + 3] = KW'(s1_dl_ff[i]);
         end else if (s2_ctl_in.above[i]) begin
            key[i]     = KW'(s1_dh_ff[i]);
            key[i + 3] = -KW'(s1_dh_ff[i]);
         end else begin
            key[i]     = '0;
            key[i + 3] = '0;
         end
      end

      // First tree level: pairs of neighbors, lower index wins a tie
      for (int j = 0; j < NUM_AXES; j++) begin
         if (key[2*j + 1] < key[2*j]) begin
            s2_key_in[j]  = key[2*j + 1];
            s2_face_in[j] = face_type'(FACE_BITS'(2*j + 1));
         end else begin
            s2_key_in[j]  = key[2*j];
            s2_face_in[j] = face_type'(FACE_BITS'(2*j));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_point_ff <= s1_point_ff;
      s2_key_ff   <= s2_key_in;
      s2_face_ff  <= s2_face_in;
   end

   assign stage_ctl   = s2_ctl_ff;
   assign stage_point = s2_point_ff;
   assign stage_key   = s2_key_ff;
   assign stage_face  = s2_face_ff;

endmodule

// File: rtl/bcpn_select.sv
// Back stages: last two levels of the minimum tree, near point selection
// and the result register. Depends on bcpn_pkg.
module bcpn_select #(
   parameter int COORD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bcpn_pkg::ctl_type                   stage_ctl,
   input  logic signed [COORD_BITS-1:0]        stage_point [bcpn_pkg::NUM_AXES],
   input  logic signed [COORD_BITS+1:0]        stage_key   [bcpn_pkg::NUM_AXES],
   input  bcpn_pkg::face_type                  stage_face  [bcpn_pkg::NUM_AXES],
   input  logic signed [COORD_BITS-1:0]        lower       [bcpn_pkg::NUM_AXES],
   input  logic signed [COORD_BITS-1:0]        upper       [bcpn_pkg::NUM_AXES],
   output logic                                rsp_strobe,
   output logic signed [COORD_BITS-1:0]        rsp_near    [bcpn_pkg::NUM_AXES],
   output logic [bcpn_pkg::FACE_BITS-1:0]      rsp_face_normal,
   output logic                                rsp_was_inside
);
   import bcpn_pkg::*;

   localparam int KW = COORD_BITS + 2;

   // Stage 3: winner of the first two pairs, third pair carried along
   ctl_type                      s3_ctl_ff;
   logic signed [COORD_BITS-1:0] s3_point_ff [NUM_AXES];
   logic signed [KW-1:0]         s3_key_ff   [2];
   face_type                     s3_face_ff  [2];
   logic signed [KW-1:0]         s3_key_in   [2];
   face_type                     s3_face_in  [2];

   // Output register
   logic                         out_strobe_ff;
   logic signed [COORD_BITS-1:0] out_near_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] out_near_in [NUM_AXES];
   face_type                     out_face_ff;
   face_type                     out_face_in;
   logic                         out_inside_ff;

   // Second tree level
   always_comb begin
      if (stage_key[1] < stage_key[0]) begin
         s3_key_in[0]  = stage_key[1];
         s3_face_in[0] = stage_face[1];
      end else begin
         s3_key_in[0]  = stage_key[0];
         s3_face_in[0] = stage_face[0];
      end
      s3_key_in[1]  = stage_key[2];
      s3_face_in[1] = stage_face[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= stage_ctl;
      end
   end

   always_ff @(posedge clock) begin
      s3_point_ff <= stage_point;
      s3_key_ff   <= s3_key_in;
      s3_face_ff  <= s3_face_in;
   end

   // Final tree level, then the near point: face projection when inside,
   // clamp (lower bound first) when outside
   always_comb begin
      if (s3_key_ff[1] < s3_key_ff[0]) begin
         out_face_in = s3_face_ff[1];
      end else begin
         out_face_in = s3_face_ff[0];
      end

      for (int a = 0; a < NUM_AXES; a++) begin
         if (s3_ctl_ff.in_box) begin
            if (out_face_in == face_type'(FACE_BITS'(a))) begin
               out_near_in[a] = upper[a];
            end else if (out_face_in == face_type'(FACE_BITS'(a + 3))) begin
               out_near_in[a] = lower[a];
            end else begin
               out_near_in[a] = s3_point_ff[a];
            end
         end else if (s3_ctl_ff.below[a]) begin
            out_near_in[a] = lower[a];
         end else if (s3_ctl_ff.above[a]) begin
            out_near_in[a] = upper[a];
         end else begin
            out_near_in[a] = s3_point_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= s3_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      out_near_ff   <= out_near_in;
      out_face_ff   <= out_face_in;
      out_inside_ff <= s3_ctl_ff.in_box;
   end

   assign rsp_strobe      = out_strobe_ff;
   assign rsp_near        = out_near_ff;
   assign rsp_face_normal = FACE_BITS'(out_face_ff);
   assign rsp_was_inside  = out_inside_ff;

endmodule

// File: rtl/box_closest_point_and_normal_top.sv
// Closest point on an axis-aligned box and the normal of the chosen face.
// Instantiates bcpn_csr, bcpn_prep and bcpn_select; depends on bcpn_pkg.
//
// A query point is taken at every clock edge where start is high and busy
// is low, one item per cycle with no gaps. Each result appears on the rsp_
// ports for one cycle with rsp_strobe high, in input order. The pipeline
// has four register stages: bound differences, key forming with the first
// compare level of the six-way minimum, second compare level, and final
// compare with near point selection. Results cannot be held off, so the
// pipeline never stalls; busy is high only while reset is asserted. The
// user must write box corners through the csr_ port only while no item is
// in flight; the block itself does not enforce this.
module box_closest_point_and_normal_top #(
   parameter int COORD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_BITS-1:0]         req_point_x,
   input  logic signed [COORD_BITS-1:0]         req_point_y,
   input  logic signed [COORD_BITS-1:0]         req_point_z,
   input  logic                                 csr_write_en,
   input  logic [bcpn_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic signed [COORD_BITS-1:0]         csr_write_data,
   output logic                                 rsp_strobe,
   output logic signed [COORD_BITS-1:0]         rsp_near_x,
   output logic signed [COORD_BITS-1:0]         rsp_near_y,
   output logic signed [COORD_BITS-1:0]         rsp_near_z,
   output logic [bcpn_pkg::FACE_BITS-1:0]       rsp_face_normal,
   output logic                                 rsp_was_inside
);
   import bcpn_pkg::*;

   logic                         accept;
   logic signed [COORD_BITS-1:0] point       [NUM_AXES];
   logic signed [COORD_BITS-1:0] lower       [NUM_AXES];
   logic signed [COORD_BITS-1:0] upper       [NUM_AXES];
   ctl_type                      stage_ctl;
   logic signed [COORD_BITS-1:0] stage_point [NUM_AXES];
   logic signed [COORD_BITS+1:0] stage_key   [NUM_AXES];
   face_type                     stage_face  [NUM_AXES];
   logic signed [COORD_BITS-1:0] near        [NUM_AXES];

   // Handshake
   assign busy   = reset;
   assign accept = start && !busy;

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   bcpn_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .lower          (lower),
      .upper          (upper)
   );

   bcpn_prep #(
      .COORD_BITS (COORD_BITS)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .point       (point),
      .lower       (lower),
      .upper       (upper),
      .stage_ctl   (stage_ctl),
      .stage_point (stage_point),
      .stage_key   (stage_key),
      .stage_face  (stage_face)
   );

   bcpn_select #(
      .COORD_BITS (COORD_BITS)
   ) u_select (
      .clock           (clock),
      .reset           (reset),
      .stage_ctl       (stage_ctl),
      .stage_point     (stage_point),
      .stage_key       (stage_key),
      .stage_face      (stage_face),
      .lower           (lower),
      .upper           (upper),
      .rsp_strobe      (rsp_strobe),
      .rsp_near        (near),
      .rsp_face_normal (rsp_face_normal),
      .rsp_was_inside  (rsp_was_inside)
   );

   assign rsp_near_x = near[0];
   assign rsp_near_y = near[1];
   assign rsp_near_z = near[2];

endmodule
